// File: rtl/core/olf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olf_pkg: shared types and constants of the six-frame ORF finder
// Codon codes, transaction structs, queue sizes and frame helpers used by
// the front classifier, the item queue, the back tracker and the top level.
// ----------------------------------------------------------------------------
package olf_pkg;

  localparam int unsigned MAX_LEN = 1048576;
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = POS_W + 1;
  localparam int BASE_W  = 3;
  localparam int HIST_W  = 2 * BASE_W;
  localparam int CODON_W = 3 * BASE_W;
  localparam int FRAMES  = 3;
  localparam int FRAME_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int RES_DEPTH   = 2;
  localparam int RES_AW      = $clog2(RES_DEPTH);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STRAND_SPECIFIC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH      = CFG_IDX_W'(1);
  localparam logic [LEN_W-1:0]     MIN_LENGTH_RESET    = LEN_W'(300);

  // Codons as three 3-bit base codes, first base in the top bits.
  localparam logic [CODON_W-1:0] CODON_ATG = 9'o032;
  localparam logic [CODON_W-1:0] CODON_TAA = 9'o300;
  localparam logic [CODON_W-1:0] CODON_TAG = 9'o302;
  localparam logic [CODON_W-1:0] CODON_TGA = 9'o320;
  localparam logic [CODON_W-1:0] CODON_CAT = 9'o103;
  localparam logic [CODON_W-1:0] CODON_TTA = 9'o330;
  localparam logic [CODON_W-1:0] CODON_CTA = 9'o130;
  localparam logic [CODON_W-1:0] CODON_TCA = 9'o310;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ATG,
    CLS_PLUS_STOP,
    CLS_CAT,
    CLS_MINUS_STOP
  } codon_cls_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              last;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] orf_start;
    logic [POS_W-1:0] orf_stop;
    logic [LEN_W-1:0] orf_length;
    logic             minus_strand;
    logic             meets_min;
    logic             too_long;
  } out_t;

  typedef struct packed {
    logic             strand_specific;
    logic [LEN_W-1:0] min_length;
  } cfg_t;

  // One classified base as it travels from the front to the back.
  typedef struct packed {
    codon_cls_t       cls;
    logic             last;
    logic             too_long;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] start_pos;
    frame_t           plus_frame;
    frame_t           minus_res;
    frame_t           n_mod;
  } item_t;

  function automatic frame_t mod3_inc(input frame_t v);
    return (v == FRAME_W'(2)) ? FRAME_W'(0) : v + FRAME_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/olf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olf_front: base intake and codon classifier
// Keeps the two previous bases, the position and its residue mod 3, and
// turns each accepted base into a classified item for the back end.
// ----------------------------------------------------------------------------
module olf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire olf_pkg::in_t  item,
  input  wire logic          q_full,
  output logic               q_push,
  output olf_pkg::item_t     q_item
);

  logic [olf_pkg::HIST_W-1:0]  recent;
  logic [olf_pkg::LEN_W-1:0]   count;
  olf_pkg::frame_t             count_mod;
  logic                        overflow;

  logic                        accept;
  logic                        ovf_now;
  logic [olf_pkg::CODON_W-1:0] codon;
  olf_pkg::codon_cls_t         cls;

  assign accept = push && !q_full;
  assign q_push = accept;
  assign ovf_now = (count >= olf_pkg::LEN_W'(olf_pkg::MAX_LEN));
  assign codon = {recent, item.base};

  always_comb begin
    cls = olf_pkg::CLS_NONE;
    if (!ovf_now && (count >= olf_pkg::LEN_W'(2))) begin
      case (codon)
        olf_pkg::CODON_ATG: cls = olf_pkg::CLS_ATG;
        olf_pkg::CODON_TAA,
        olf_pkg::CODON_TAG,
        olf_pkg::CODON_TGA: cls = olf_pkg::CLS_PLUS_STOP;
        olf_pkg::CODON_CAT: cls = olf_pkg::CLS_CAT;
        olf_pkg::CODON_TTA,
        olf_pkg::CODON_CTA,
        olf_pkg::CODON_TCA: cls = olf_pkg::CLS_MINUS_STOP;
        default:            cls = olf_pkg::CLS_NONE;
      endcase
    end
  end

  always_comb begin
    q_item.cls        = cls;
    q_item.last       = item.last;
    q_item.too_long   = overflow || ovf_now;
    q_item.pos        = count[olf_pkg::POS_W-1:0];
    q_item.start_pos  = count[olf_pkg::POS_W-1:0] - olf_pkg::POS_W'(2);
    q_item.plus_frame = olf_pkg::mod3_inc(count_mod);
    q_item.minus_res  = count_mod;
    // Sequence length mod 3 after this base; an ignored base leaves it alone.
    q_item.n_mod      = ovf_now ? count_mod : olf_pkg::mod3_inc(count_mod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent    <= '0;
      count     <= '0;
      count_mod <= '0;
      overflow  <= 1'b0;
    end else if (accept) begin
      if (item.last) begin
        recent    <= '0;
        count     <= '0;
        count_mod <= '0;
        overflow  <= 1'b0;
      end else begin
        overflow <= overflow || ovf_now;
        if (!ovf_now) begin
          recent    <= codon[olf_pkg::HIST_W-1:0];
          count     <= count + olf_pkg::LEN_W'(1);
          count_mod <= olf_pkg::mod3_inc(count_mod);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/olf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olf_queue: short item queue between front and back
// A small register queue that decouples the classifier from the trackers.
// ----------------------------------------------------------------------------
module olf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire olf_pkg::item_t  wr_item,
  output logic                 full,
  input  wire logic            rd_en,
  output olf_pkg::item_t       rd_item,
  output logic                 empty
);

  olf_pkg::item_t                entries [olf_pkg::QUEUE_DEPTH];
  logic [olf_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [olf_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [olf_pkg::QUEUE_AW:0]    count;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (count == (olf_pkg::QUEUE_AW + 1)'(olf_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + olf_pkg::QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + olf_pkg::QUEUE_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (olf_pkg::QUEUE_AW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (olf_pkg::QUEUE_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/olf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olf_back: per-frame ORF trackers, final selection and result queue
// Updates the three plus frames and three minus residues for each item,
// snapshots the per-frame bests on the last base, picks the answer and
// queues it.
// ----------------------------------------------------------------------------
module olf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire olf_pkg::cfg_t   cfg,
  input  wire logic            q_empty,
  input  wire olf_pkg::item_t  q_item,
  output logic                 q_pop,
  input  wire logic            res_pop,
  output logic                 res_empty,
  output olf_pkg::out_t        res
);

  localparam int NF = olf_pkg::FRAMES;
  localparam int PW = olf_pkg::POS_W;
  localparam int LW = olf_pkg::LEN_W;

  // Tracker state.
  logic [NF-1:0] plus_open, plus_open_next;
  logic [PW-1:0] plus_open_start [NF];
  logic [PW-1:0] plus_open_start_next [NF];
  logic [LW-1:0] plus_best_len [NF];
  logic [LW-1:0] plus_best_len_next [NF];
  logic [PW-1:0] plus_best_start [NF];
  logic [PW-1:0] plus_best_start_next [NF];
  logic [LW-1:0] plus_cand_len [NF];

  logic [NF-1:0] minus_stop_seen, minus_stop_seen_next;
  logic [NF-1:0] minus_start_seen, minus_start_seen_next;
  logic [NF-1:0] minus_start_seen_eff;
  logic [PW-1:0] minus_stop_pos [NF];
  logic [PW-1:0] minus_stop_pos_next [NF];
  logic [PW-1:0] minus_start_pos [NF];
  logic [PW-1:0] minus_start_pos_next [NF];
  logic [LW-1:0] minus_best_len [NF];
  logic [LW-1:0] minus_best_len_next [NF];
  logic [PW-1:0] minus_best_start [NF];
  logic [PW-1:0] minus_best_start_next [NF];
  logic [LW-1:0] minus_cand_len [NF];

  // Finish stage snapshot.
  logic            fin_valid;
  logic [LW-1:0]   fin_plus_len [NF];
  logic [PW-1:0]   fin_plus_start [NF];
  logic [LW-1:0]   fin_minus_len [NF];
  logic [PW-1:0]   fin_minus_start [NF];
  olf_pkg::frame_t fin_n_mod;
  logic            fin_too_long;

  logic [LW-1:0] ml [NF];
  logic [PW-1:0] ms [NF];
  logic [LW-1:0] sel_len;
  logic [PW-1:0] sel_start;
  logic          sel_minus;
  logic [LW-1:0] stop_wide;
  olf_pkg::out_t fin_res;

  // Result queue.
  olf_pkg::out_t              res_entries [olf_pkg::RES_DEPTH];
  logic [olf_pkg::RES_AW-1:0] res_wr_ptr;
  logic [olf_pkg::RES_AW-1:0] res_rd_ptr;
  logic [olf_pkg::RES_AW:0]   res_count;
  logic                       res_full;
  logic                       res_push;
  logic                       res_take;

  logic stall;
  logic pop_last;

  assign res_full  = (res_count == (olf_pkg::RES_AW + 1)'(olf_pkg::RES_DEPTH));
  assign res_empty = (res_count == '0);
  assign stall     = fin_valid && res_full;
  assign q_pop     = !q_empty && !stall;
  assign pop_last  = q_pop && q_item.last;
  assign res_push  = fin_valid && !res_full;
  assign res_take  = res_pop && !res_empty;
  assign res       = res_entries[res_rd_ptr];

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      // Plus frame f.
      plus_open_next[f]       = plus_open[f];
      plus_open_start_next[f] = plus_open_start[f];
      plus_best_len_next[f]   = plus_best_len[f];
      plus_best_start_next[f] = plus_best_start[f];
      plus_cand_len[f] = {1'b0, q_item.start_pos} - {1'b0, plus_open_start[f]} + LW'(3);
      if (q_pop && (q_item.plus_frame == olf_pkg::FRAME_W'(f))) begin
        case (q_item.cls)
          olf_pkg::CLS_ATG: begin
            if (!plus_open[f]) begin
              plus_open_next[f]       = 1'b1;
              plus_open_start_next[f] = q_item.start_pos;
            end
          end
          olf_pkg::CLS_PLUS_STOP: begin
            if (plus_open[f]) begin
              if (plus_cand_len[f] > plus_best_len[f]) begin
                plus_best_len_next[f]   = plus_cand_len[f];
                plus_best_start_next[f] = plus_open_start[f];
              end
              plus_open_next[f] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // Minus residue f: a CAT on this base counts before the close.
      minus_start_seen_eff[f]  = minus_start_seen[f];
      minus_start_pos_next[f]  = minus_start_pos[f];
      minus_stop_seen_next[f]  = minus_stop_seen[f];
      minus_stop_pos_next[f]   = minus_stop_pos[f];
      minus_best_len_next[f]   = minus_best_len[f];
      minus_best_start_next[f] = minus_best_start[f];
      if (q_pop && (q_item.minus_res == olf_pkg::FRAME_W'(f)) &&
          (q_item.cls == olf_pkg::CLS_CAT) && minus_stop_seen[f]) begin
        minus_start_seen_eff[f] = 1'b1;
        minus_start_pos_next[f] = q_item.pos;
      end
      minus_cand_len[f] = {1'b0, minus_start_pos_next[f]} - {1'b0, minus_stop_pos[f]}
                          + LW'(3);
      if (pop_last || (q_pop && (q_item.minus_res == olf_pkg::FRAME_W'(f)) &&
                       (q_item.cls == olf_pkg::CLS_MINUS_STOP))) begin
        if (minus_start_seen_eff[f] && minus_stop_seen[f] &&
            (minus_cand_len[f] >= minus_best_len[f])) begin
          minus_best_len_next[f]   = minus_cand_len[f];
          minus_best_start_next[f] = minus_start_pos_next[f];
        end
        minus_start_seen_next[f] = 1'b0;
      end else begin
        minus_start_seen_next[f] = minus_start_seen_eff[f];
      end
      if (q_pop && (q_item.minus_res == olf_pkg::FRAME_W'(f)) &&
          (q_item.cls == olf_pkg::CLS_MINUS_STOP)) begin
        minus_stop_seen_next[f] = 1'b1;
        minus_stop_pos_next[f]  = q_item.pos;
      end
    end
  end

  // Control state and best lengths; everything clears after the last base.
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_open        <= '0;
      minus_stop_seen  <= '0;
      minus_start_seen <= '0;
      for (int f = 0; f < NF; f++) begin
        plus_best_len[f]  <= '0;
        minus_best_len[f] <= '0;
      end
    end else if (q_pop) begin
      if (q_item.last) begin
        plus_open        <= '0;
        minus_stop_seen  <= '0;
        minus_start_seen <= '0;
        for (int f = 0; f < NF; f++) begin
          plus_best_len[f]  <= '0;
          minus_best_len[f] <= '0;
        end
      end else begin
        plus_open        <= plus_open_next;
        minus_stop_seen  <= minus_stop_seen_next;
        minus_start_seen <= minus_start_seen_next;
        for (int f = 0; f < NF; f++) begin
          plus_best_len[f]  <= plus_best_len_next[f];
          minus_best_len[f] <= minus_best_len_next[f];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int f = 0; f < NF; f++) begin
        plus_open_start[f]  <= plus_open_start_next[f];
        plus_best_start[f]  <= plus_best_start_next[f];
        minus_stop_pos[f]   <= minus_stop_pos_next[f];
        minus_start_pos[f]  <= minus_start_pos_next[f];
        minus_best_start[f] <= minus_best_start_next[f];
      end
    end
    if (pop_last) begin
      for (int f = 0; f < NF; f++) begin
        fin_plus_len[f]    <= plus_best_len_next[f];
        fin_plus_start[f]  <= plus_best_start_next[f];
        fin_minus_len[f]   <= minus_best_len_next[f];
        fin_minus_start[f] <= minus_best_start_next[f];
      end
      fin_n_mod    <= q_item.n_mod;
      fin_too_long <= q_item.too_long;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (!stall) begin
      fin_valid <= pop_last;
    end
  end

  // Minus frames are numbered from the sequence end: frame k holds the
  // residue (n + 2 - k) mod 3.
  always_comb begin
    case (fin_n_mod)
      olf_pkg::FRAME_W'(1): begin
        ml[0] = fin_minus_len[0]; ms[0] = fin_minus_start[0];
        ml[1] = fin_minus_len[2]; ms[1] = fin_minus_start[2];
        ml[2] = fin_minus_len[1]; ms[2] = fin_minus_start[1];
      end
      olf_pkg::FRAME_W'(2): begin
        ml[0] = fin_minus_len[1]; ms[0] = fin_minus_start[1];
        ml[1] = fin_minus_len[0]; ms[1] = fin_minus_start[0];
        ml[2] = fin_minus_len[2]; ms[2] = fin_minus_start[2];
      end
      default: begin
        ml[0] = fin_minus_len[2]; ms[0] = fin_minus_start[2];
        ml[1] = fin_minus_len[1]; ms[1] = fin_minus_start[1];
        ml[2] = fin_minus_len[0]; ms[2] = fin_minus_start[0];
      end
    endcase
  end

  always_comb begin
    sel_minus = 1'b0;
    if ((fin_plus_len[0] > fin_plus_len[1]) && (fin_plus_len[0] > fin_plus_len[2])) begin
      sel_len   = fin_plus_len[0];
      sel_start = fin_plus_start[0];
    end else if (fin_plus_len[1] > fin_plus_len[2]) begin
      sel_len   = fin_plus_len[1];
      sel_start = fin_plus_start[1];
    end else begin
      sel_len   = fin_plus_len[2];
      sel_start = fin_plus_start[2];
    end
    if (!cfg.strand_specific) begin
      if ((ml[0] > ml[1]) && (ml[0] > ml[2]) && (ml[0] > sel_len)) begin
        sel_len   = ml[0];
        sel_start = ms[0];
        sel_minus = 1'b1;
      end else if ((ml[1] > ml[2]) && (ml[1] > sel_len)) begin
        sel_len   = ml[1];
        sel_start = ms[1];
        sel_minus = 1'b1;
      end else if (ml[2] > sel_len) begin
        sel_len   = ml[2];
        sel_start = ms[2];
        sel_minus = 1'b1;
      end
    end

    if (sel_minus) begin
      stop_wide = {1'b0, sel_start} - sel_len + LW'(1);
    end else begin
      stop_wide = {1'b0, sel_start} + sel_len - LW'(1);
    end

    fin_res.orf_length   = sel_len;
    fin_res.minus_strand = sel_minus;
    fin_res.meets_min    = (sel_len >= cfg.min_length);
    fin_res.too_long     = fin_too_long;
    if (sel_len != '0) begin
      fin_res.orf_start = sel_start;
      fin_res.orf_stop  = stop_wide[PW-1:0];
    end else begin
      fin_res.orf_start = '0;
      fin_res.orf_stop  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= res_wr_ptr + olf_pkg::RES_AW'(1);
      end
      if (res_take) begin
        res_rd_ptr <= res_rd_ptr + olf_pkg::RES_AW'(1);
      end
      if (res_push && !res_take) begin
        res_count <= res_count + (olf_pkg::RES_AW + 1)'(1);
      end else if (res_take && !res_push) begin
        res_count <= res_count - (olf_pkg::RES_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_entries[res_wr_ptr] <= fin_res;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/longest_orf_six_frame_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_orf_six_frame_finder: streaming six-frame longest ORF search
// Top level: configuration registers, classifier front, item queue and the
// tracker back end with its result queue.
// ----------------------------------------------------------------------------
// Usage: nucleotides enter one per transaction on the input queue port
// (push/full, payload item.base and item.last). The transaction that carries
// last ends the sequence and causes exactly one result transaction on the
// output queue port (empty/pop, payload result) with the longest
// stop-terminated ORF over both strands, or over the plus strand alone
// when strand_specific is set; all other bases cause none.
// The block takes one base per cycle for as long as the consumer keeps up.
// A result passes the item queue and the finish stage, which picks the
// frame, before it shows on the output. The trackers update on each base
// and clear on the last one, so a new sequence can follow it directly.
// If the consumer stops popping, the two-entry result queue fills, the
// finish stage holds, the back end stops draining the four-entry item
// queue, and full rises once that queue is full; no result is ever dropped.
// Configuration (strand_specific, min_length) is written through cfg_valid/
// cfg_ready, which is always ready, and should only change while idle.
// Reset empties all queues, clears the tracker flags and best lengths and
// loads strand_specific 0 and min_length 300.
// ----------------------------------------------------------------------------
module longest_orf_six_frame_finder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire olf_pkg::in_t                    item,
  output logic                                 full,
  input  wire logic                            pop,
  output olf_pkg::out_t                        result,
  output logic                                 empty,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [olf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [olf_pkg::LEN_W-1:0]       cfg_data
);

  olf_pkg::cfg_t  cfg;
  logic           q_push;
  olf_pkg::item_t q_wr_item;
  logic           q_full;
  logic           q_pop;
  olf_pkg::item_t q_rd_item;
  logic           q_empty;

  // The register file never stalls a configuration transaction.
  assign cfg_ready = 1'b1;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strand_specific <= 1'b0;
      cfg.min_length      <= olf_pkg::MIN_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        olf_pkg::REG_STRAND_SPECIFIC: cfg.strand_specific <= cfg_data[0];
        olf_pkg::REG_MIN_LENGTH:      cfg.min_length      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: tracks position and the last two bases, classifies each codon.
  olf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wr_item)
  );

  olf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  // Back: per-frame trackers, frame selection and the result queue.
  olf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (result)
  );

`ifndef SYNTH
  // The result queue comes out of reset empty.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // Input back-pressure only comes from a filled item queue.
  assert property (@(posedge clk) disable iff (rst) full |-> !q_empty)
    else $error("full raised while the item queue is empty");

  // A minus-strand answer always has a real ORF behind it.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.minus_strand) |-> (result.orf_length != '0))
    else $error("minus strand flagged on an empty result");

  // No ORF means zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.orf_length == '0)) |->
      ((result.orf_start == '0) && (result.orf_stop == '0)))
    else $error("nonzero coordinates on an empty result");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the six-frame longest ORF finder
// Streams nucleotide sequences into the block through its input queue port,
// predicts the one result that each sequence ends with, and compares every
// popped result field by field. Directed sequences cover the corner cases,
// and random traffic runs under several register settings, with random
// stalls on both sides in all but the last idle profile.
// ----------------------------------------------------------------------------
module testbench;
  import olf_pkg::*;

  // Base codes as the block sees them. Codes from BASE_N up to BASE_X stand
  // for any character that is not a nucleotide.
  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T = 3'd3;
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;
  localparam logic [BASE_W-1:0] BASE_X = 3'd7;

  // A result passes the item queue and the finish stage before it shows;
  // this leaves a margin on top of that before registers are touched.
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_SETTING = 105;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  in_t item = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic full;
  logic empty;
  logic cfg_ready;
  out_t result;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longest_orf_six_frame_finder uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .pop(pop),
    .result(result),
    .empty(empty),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Percent chance that the sender inserts an idle cycle before a base, and
  // that the receiver holds pop low in a given cycle.
  int unsigned tx_idle_pct = 18;
  int unsigned rx_idle_pct = 51;
  int unsigned error_count = 0;

  // Results predicted for accepted sequences, oldest first.
  out_t expected_orfs[$];
  // Bases of the sequence that is about to be sent.
  logic [BASE_W-1:0] pending_bases[$];

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the register settings as written and the
  // per-frame tracking of the sequence in flight.
  // --------------------------------------------------------------------------
  logic strand_only = 1'b0;
  logic [LEN_W-1:0] min_len_cfg = MIN_LENGTH_RESET;

  logic [HIST_W-1:0] prev_two;
  logic [LEN_W-1:0] seq_len;
  logic seq_overflow;
  // Plus strand, indexed by start position mod 3.
  logic fwd_open[FRAMES];
  logic [POS_W-1:0] fwd_open_at[FRAMES];
  logic [LEN_W-1:0] fwd_best_len[FRAMES];
  logic [POS_W-1:0] fwd_best_at[FRAMES];
  // Minus strand, indexed by the position of the codon's last base mod 3.
  logic rev_stop_valid[FRAMES];
  logic [POS_W-1:0] rev_stop_at[FRAMES];
  logic rev_cat_valid[FRAMES];
  logic [POS_W-1:0] rev_cat_at[FRAMES];
  logic [LEN_W-1:0] rev_best_len[FRAMES];
  logic [POS_W-1:0] rev_best_at[FRAMES];

  function automatic void clear_tracking();
    prev_two = '0;
    seq_len = '0;
    seq_overflow = 1'b0;
    for (int k = 0; k < FRAMES; k++) begin
      fwd_open[k] = 1'b0;
      fwd_open_at[k] = '0;
      fwd_best_len[k] = '0;
      fwd_best_at[k] = '0;
      rev_stop_valid[k] = 1'b0;
      rev_stop_at[k] = '0;
      rev_cat_valid[k] = 1'b0;
      rev_cat_at[k] = '0;
      rev_best_len[k] = '0;
      rev_best_at[k] = '0;
    end
  endfunction

  // Pairs the pending CAT of a minus residue with the stop below it. The
  // comparison is not strict, so a higher pair of equal length wins.
  function automatic void close_reverse(int r);
    logic [LEN_W-1:0] span;
    if (rev_cat_valid[r] && rev_stop_valid[r]) begin
      span = LEN_W'(rev_cat_at[r]) - LEN_W'(rev_stop_at[r]) + LEN_W'(3);
      if (span >= rev_best_len[r]) begin
        rev_best_len[r] = span;
        rev_best_at[r] = rev_cat_at[r];
      end
    end
    rev_cat_valid[r] = 1'b0;
  endfunction

  // Shifts one base into the codon window and updates both strands.
  function automatic void track_codon(logic [BASE_W-1:0] b);
    logic [CODON_W-1:0] codon;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] s;
    logic [LEN_W-1:0] span;
    int fr;
    int r;
    p = seq_len[POS_W-1:0];
    codon = {prev_two, b};
    prev_two = codon[HIST_W-1:0];
    seq_len = seq_len + LEN_W'(1);
    if (p < 2) return;

    s = p - POS_W'(2);
    fr = s % 3;
    if (codon == CODON_ATG) begin
      if (!fwd_open[fr]) begin
        fwd_open[fr] = 1'b1;
        fwd_open_at[fr] = s;
      end
    end else if (codon == CODON_TAA || codon == CODON_TAG || codon == CODON_TGA) begin
      if (fwd_open[fr]) begin
        span = LEN_W'(s) - LEN_W'(fwd_open_at[fr]) + LEN_W'(3);
        // Strictly longer only: the earliest ORF of a length is kept.
        if (span > fwd_best_len[fr]) begin
          fwd_best_len[fr] = span;
          fwd_best_at[fr] = fwd_open_at[fr];
        end
        fwd_open[fr] = 1'b0;
      end
    end

    r = p % 3;
    if (codon == CODON_TTA || codon == CODON_CTA || codon == CODON_TCA) begin
      close_reverse(r);
      rev_stop_valid[r] = 1'b1;
      rev_stop_at[r] = p;
    end else if (codon == CODON_CAT) begin
      if (rev_stop_valid[r]) begin
        rev_cat_valid[r] = 1'b1;
        rev_cat_at[r] = p;
      end
    end
  endfunction

  // Called once per accepted base. On the last base of a sequence it picks
  // the winning frame, queues the expected result and starts over.
  function automatic void follow_base(logic [BASE_W-1:0] b, logic is_last);
    logic [LEN_W-1:0] best_len;
    logic [POS_W-1:0] best_at;
    logic [POS_W-1:0] end_at;
    logic from_rev;
    logic [LEN_W-1:0] rl[FRAMES];
    int ri[FRAMES];
    int pick;
    int unsigned n;
    out_t want;
    if (seq_len >= LEN_W'(MAX_LEN)) begin
      seq_overflow = 1'b1;
    end else begin
      track_codon(b);
    end
    if (!is_last) return;

    for (int k = 0; k < FRAMES; k++) close_reverse(k);

    // Plus frame priority: frame 0 must beat both, then frame 1 beat 2.
    if (fwd_best_len[0] > fwd_best_len[1] && fwd_best_len[0] > fwd_best_len[2]) begin
      best_len = fwd_best_len[0];
      best_at = fwd_best_at[0];
    end else if (fwd_best_len[1] > fwd_best_len[2]) begin
      best_len = fwd_best_len[1];
      best_at = fwd_best_at[1];
    end else begin
      best_len = fwd_best_len[2];
      best_at = fwd_best_at[2];
    end

    // Minus frames count from the sequence end and must strictly beat the
    // plus choice to take over.
    from_rev = 1'b0;
    if (!strand_only) begin
      n = 32'(seq_len);
      for (int k = 0; k < FRAMES; k++) begin
        ri[k] = (n + 5 - k) % 3;
        rl[k] = rev_best_len[ri[k]];
      end
      pick = -1;
      if (rl[0] > rl[1] && rl[0] > rl[2] && rl[0] > best_len) pick = 0;
      else if (rl[1] > rl[2] && rl[1] > best_len) pick = 1;
      else if (rl[2] > best_len) pick = 2;
      if (pick >= 0) begin
        best_len = rl[pick];
        best_at = rev_best_at[ri[pick]];
        from_rev = 1'b1;
      end
    end

    if (best_len != 0) begin
      end_at = from_rev ? POS_W'(best_at - best_len + 1'b1)
                        : POS_W'(best_at + best_len - 1'b1);
    end else begin
      best_at = '0;
      end_at = '0;
    end

    want.orf_start = best_at;
    want.orf_stop = end_at;
    want.orf_length = best_len;
    want.minus_strand = from_rev;
    want.meets_min = (best_len >= min_len_cfg);
    want.too_long = seq_overflow;
    expected_orfs.push_back(want);
    clear_tracking();
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pop at random, check every result transaction in order.
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [LEN_W-1:0] want,
                                        logic [LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (expected_orfs.size() == 0) begin
      $error("result transaction with no expected ORF waiting (length %0d)",
             got.orf_length);
      error_count++;
      return;
    end
    want = expected_orfs.pop_front();
    compare_field("orf_start", LEN_W'(want.orf_start), LEN_W'(got.orf_start));
    compare_field("orf_stop", LEN_W'(want.orf_stop), LEN_W'(got.orf_stop));
    compare_field("orf_length", want.orf_length, got.orf_length);
    compare_field("minus_strand", LEN_W'(want.minus_strand), LEN_W'(got.minus_strand));
    compare_field("meets_min", LEN_W'(want.meets_min), LEN_W'(got.meets_min));
    compare_field("too_long", LEN_W'(want.too_long), LEN_W'(got.too_long));
  endfunction

  // Values read right after the edge are the ones the block sampled there,
  // since its own updates land later in the same time step.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Offers one base and returns once the block has taken it. push is left
  // high so back-to-back bases go out without a gap; the next call (when it
  // inserts an idle cycle) or a drain lowers it.
  task automatic send_base(input logic [BASE_W-1:0] b, input logic is_last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= {b, is_last};
    do @(posedge clk); while (full);
    follow_base(b, is_last);
  endtask

  task automatic queue_codon(input logic [CODON_W-1:0] codon);
    pending_bases.push_back(codon[8:6]);
    pending_bases.push_back(codon[5:3]);
    pending_bases.push_back(codon[2:0]);
  endtask

  // Sends the staged bases as one sequence, marking the final one last.
  task automatic send_pending();
    for (int i = 0; i < pending_bases.size(); i++) begin
      send_base(pending_bases[i], i == pending_bases.size() - 1);
    end
    pending_bases.delete();
  endtask

  // Holds the sender until every expected result has been popped, then lets
  // the block settle. Register writes only happen after this.
  task automatic wait_for_results();
    push <= 1'b0;
    while (expected_orfs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sets cfg_valid and waits for its transaction; it does not lower valid,
  // so two writes in a row keep it high between them.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [LEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_STRAND_SPECIFIC) strand_only = data[0];
    else min_len_cfg = data;
  endtask

  task automatic configure(input logic strand_specific, input logic [LEN_W-1:0] min_len);
    wait_for_results();
    write_register(REG_STRAND_SPECIFIC, LEN_W'(strand_specific));
    write_register(REG_MIN_LENGTH, min_len);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Registers still hold their reset values: a six-base plus ORF falls
  // short of the default minimum of 300.
  task automatic test_reset_defaults();
    queue_codon(CODON_ATG);
    queue_codon(CODON_TAA);
    send_pending();
  endtask

  // One and two bases can hold no codon; with a minimum of zero an empty
  // answer still meets it.
  task automatic test_short_sequences();
    configure(1'b0, '0);
    pending_bases.push_back(BASE_A);
    send_pending();
    pending_bases.push_back(BASE_G);
    pending_bases.push_back(BASE_C);
    send_pending();
  endtask

  // TTA followed by CAT in the same residue reads as ATG...TAA backward.
  task automatic test_minus_strand_orf();
    configure(1'b0, LEN_W'(6));
    queue_codon(CODON_TTA);
    queue_codon(CODON_CAT);
    send_pending();
  endtask

  // Non-nucleotide codes spoil codons: the would-be TAA right after the
  // ATG is broken, so the later TAG closes a nine-base ORF instead.
  task automatic test_unknown_codes();
    configure(1'b0, LEN_W'(10));
    pending_bases.push_back(BASE_N);
    queue_codon(CODON_ATG);
    pending_bases.push_back(BASE_T);
    pending_bases.push_back(BASE_X);
    pending_bases.push_back(BASE_A);
    queue_codon(CODON_TAG);
    pending_bases.push_back(BASE_X);
    send_pending();
  endtask

  function automatic logic [CODON_W-1:0] pick_codon(int unsigned sel);
    case (sel)
      0: return CODON_ATG;
      1: return CODON_TAA;
      2: return CODON_TAG;
      3: return CODON_TGA;
      4: return CODON_CAT;
      5: return CODON_TTA;
      6: return CODON_CTA;
      default: return CODON_TCA;
    endcase
  endfunction

  // Mostly short sequences so results come often. About a third of the
  // picks drop a whole start or stop codon in at a random offset, which
  // keeps ORFs forming on both strands; the rest are plain or unknown bases.
  task automatic build_random_sequence();
    int unsigned len;
    int unsigned roll;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30) : $urandom_range(31, 120);
    while (pending_bases.size() < len) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) queue_codon(pick_codon($urandom_range(0, 7)));
      else if (roll < 40) pending_bases.push_back(BASE_W'($urandom_range(BASE_N, BASE_X)));
      else pending_bases.push_back(BASE_W'($urandom_range(BASE_A, BASE_T)));
    end
    while (pending_bases.size() > len) void'(pending_bases.pop_back());
  endtask

  task automatic send_random_sequences(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      build_random_sequence();
      sent += pending_bases.size();
      send_pending();
    end
  endtask

  // Three idle profiles, each run under four register settings. The third
  // setting sets min_length to 0, MAX_LEN - 1 and MAX_LEN in turn, and the
  // last one puts the reset values back.
  task automatic test_random_traffic();
    logic [LEN_W-1:0] extreme;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 51;
          extreme = '0;
        end
        1: begin
          tx_idle_pct = 51;
          rx_idle_pct = 18;
          extreme = LEN_W'(MAX_LEN - 1);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          extreme = LEN_W'(MAX_LEN);
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: configure(1'b0, LEN_W'($urandom_range(0, 40)));
          1: configure(1'b1, LEN_W'($urandom_range(0, 40)));
          2: configure(phase[0], extreme);
          default: configure(1'b0, MIN_LENGTH_RESET);
        endcase
        send_random_sequences(ITEMS_PER_SETTING);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Run order and end of test.
  // --------------------------------------------------------------------------
  initial begin
    clear_tracking();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_short_sequences();
    test_minus_strand_orf();
    test_unknown_codes();
    test_random_traffic();
    wait_for_results();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Even with every base ending a sequence under the heaviest stalls, a
  // correct run finishes well inside this limit, which ends a run that
  // hangs.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
